[hdl/vctp_pkg.sv]
package vctp_pkg;

  // build-time defaults of the viewport resolution
  localparam int VIEW_COLUMNS_DEF = 1024;
  localparam int VIEW_ROWS_DEF    = 1024;

  // field widths
  localparam int PIX_W      = 10;
  localparam int TRIG_W     = 18;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // input queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // view size after reset, unsigned Q15.16
  localparam logic [30:0] VIEW_WIDTH_RST  = 31'd3276800;
  localparam logic [30:0] VIEW_HEIGHT_RST = 31'd1638400;

  // Q4.28 constants of the sine and cosine evaluation
  localparam logic [28:0]        Q28_ONE     = 29'd268435456;
  localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
  localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;

  // horner step numbers: sine runs steps 0..4, cosine 5..10
  localparam logic [3:0] SINE_LAST_STEP = 4'd4;
  localparam logic [3:0] COS_LAST_STEP  = 4'd10;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic               visible;
    logic [PIX_W-1:0]   pixel_column;
    logic [PIX_W-1:0]   pixel_row;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_X = 4'd0,
    REG_ANGLE_Y = 4'd1,
    REG_ANGLE_Z = 4'd2,
    REG_POS_X   = 4'd3,
    REG_POS_Y   = 4'd4,
    REG_POS_Z   = 4'd5,
    REG_VIEW_W  = 4'd6,
    REG_VIEW_H  = 4'd7
  } reg_index_t;

  // settings seen by the transform pipeline
  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_z;
    logic signed [TRIG_W-1:0] cos_z;
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic signed [31:0]       pos_z;
    logic [30:0]              view_width;
    logic [30:0]              view_height;
  } view_cfg_t;

  typedef enum logic [3:0] {
    TRIG_IDLE,
    TRIG_SQR,
    TRIG_X2,
    TRIG_MUL,
    TRIG_RCP,
    TRIG_FIX,
    TRIG_SINM,
    TRIG_SINR,
    TRIG_FIN
  } trig_state_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_stat_t;

  // divisor of each horner step
  function automatic logic [7:0] horner_div(input logic [3:0] step);
    logic [7:0] k;
    case (step)
      4'd0:    k = 8'd110;
      4'd1:    k = 8'd72;
      4'd2:    k = 8'd42;
      4'd3:    k = 8'd20;
      4'd4:    k = 8'd6;
      4'd5:    k = 8'd132;
      4'd6:    k = 8'd90;
      4'd7:    k = 8'd56;
      4'd8:    k = 8'd30;
      4'd9:    k = 8'd12;
      4'd10:   k = 8'd2;
      default: k = 8'd1;
    endcase
    return k;
  endfunction

  // floor(2^32 / divisor) of each horner step
  function automatic logic [31:0] horner_recip(input logic [3:0] step);
    logic [31:0] m;
    case (step)
      4'd0:    m = 32'd39045157;
      4'd1:    m = 32'd59652323;
      4'd2:    m = 32'd102261126;
      4'd3:    m = 32'd214748364;
      4'd4:    m = 32'd715827882;
      4'd5:    m = 32'd32537631;
      4'd6:    m = 32'd47721858;
      4'd7:    m = 32'd76695844;
      4'd8:    m = 32'd143165576;
      4'd9:    m = 32'd357913941;
      4'd10:   m = 32'd2147483648;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

[hdl/vertex_camera_transform_project_top.sv]
// Camera transform and orthographic projection: each vertex pushed in (signed Q16.16 x, y, z)
// is rotated by the negated camera angles about x, then y, then z, the camera position is
// subtracted, and a result with the saturated camera-space point, a visible flag and the pixel
// column and row comes out in push order. One vertex is accepted per clock while full is low;
// each vertex passes through the six rotation stages, four projection stages and the
// one-bit-per-stage pixel dividers. A write of an angle register makes the shared-multiplier
// sine and cosine sequencer run; while it runs cfg_ready is low and full is held high.
// Other register writes take effect at once. Write registers only while no vertex is in flight.
module vertex_camera_transform_project_top #(
  parameter int VIEW_COLUMNS = vctp_pkg::VIEW_COLUMNS_DEF,
  parameter int VIEW_ROWS    = vctp_pkg::VIEW_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  vctp_pkg::in_item_t              in_data,
  output logic                            out_empty,
  input  logic                            out_pop,
  output vctp_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vctp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vctp_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                q_valid;
  logic                q_take;
  vctp_pkg::in_item_t  q_item;
  vctp_pkg::view_cfg_t view_cfg;

  // input queue, registers and trig table
  vctp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .view_cfg  (view_cfg)
  );

  // transform pipeline and result queue
  vctp_back #(
    .VIEW_COLUMNS (VIEW_COLUMNS),
    .VIEW_ROWS    (VIEW_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .view_cfg  (view_cfg),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // no results right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // vertices are held off while sine and cosine are evaluated
  a_trig_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ready |-> in_full)
    else $error("vertex accepted during angle evaluation");

  // the config port only goes busy after an angle write transfer
  a_busy_after_angle: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(cfg_ready) |-> $past(cfg_valid && cfg_ready &&
      ((cfg_index == vctp_pkg::REG_ANGLE_X) || (cfg_index == vctp_pkg::REG_ANGLE_Y) ||
       (cfg_index == vctp_pkg::REG_ANGLE_Z))))
    else $error("config port busy without an angle write");

endmodule

[hdl/vctp_trig.sv]
module vctp_trig (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [15:0]            angle,
  output vctp_pkg::trig_stat_t   stat
);

  vctp_pkg::trig_state_t state_r, state_nxt;

  logic [28:0]        ax_r;
  logic               neg_r;
  logic               flip_r;
  logic [63:0]        prod_r;
  logic [29:0]        x2_r;
  logic [29:0]        v_r;
  logic signed [30:0] t_r;
  logic [3:0]         step_r;
  logic [16:0]        smag_r;

  logic signed [16:0] nang;
  logic signed [33:0] th;
  logic signed [33:0] thf;
  logic signed [33:0] axf;
  logic               flipf;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [7:0]         kdiv;
  logic [29:0]        q0;
  logic [37:0]        qk;
  logic [37:0]        rem;
  logic [29:0]        qf;
  logic signed [30:0] t_fix;
  logic [30:0]        sraw;
  logic [18:0]        srnd;
  logic [16:0]        smag;
  logic [29:0]        cpos;
  logic [30:0]        craw;
  logic [16:0]        cmag;

  // fold the negated angle into [-pi/2, pi/2]
  always_comb begin
    nang = 17'sd0 - $signed({angle[15], angle});
    th   = $signed({{2{nang[16]}}, nang, 15'd0});
    if (th > vctp_pkg::Q28_HALF_PI) begin
      thf   = th - vctp_pkg::Q28_PI;
      flipf = 1'b1;
    end else if (th < -vctp_pkg::Q28_HALF_PI) begin
      thf   = th + vctp_pkg::Q28_PI;
      flipf = 1'b1;
    end else begin
      thf   = th;
      flipf = 1'b0;
    end
    axf = thf[33] ? -thf : thf;
  end

  // shared multiplier operands
  always_comb begin
    case (state_r)
      vctp_pkg::TRIG_SQR: begin
        mul_a = 32'(ax_r);
        mul_b = 32'(ax_r);
      end
      vctp_pkg::TRIG_MUL: begin
        mul_a = 32'(x2_r);
        mul_b = 32'(t_r[29:0]);
      end
      vctp_pkg::TRIG_RCP: begin
        mul_a = 32'(prod_r[57:28]);
        mul_b = vctp_pkg::horner_recip(step_r);
      end
      vctp_pkg::TRIG_SINM: begin
        mul_a = 32'(ax_r);
        mul_b = 32'(t_r[29:0]);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // quotient by reciprocal with one correction, then next horner term
  always_comb begin
    kdiv  = vctp_pkg::horner_div(step_r);
    q0    = prod_r[61:32];
    qk    = 38'(q0) * 38'(kdiv);
    rem   = 38'(v_r) - qk;
    qf    = (rem >= 38'(kdiv)) ? (q0 + 30'd1) : q0;
    t_fix = $signed({2'b00, vctp_pkg::Q28_ONE}) - $signed({1'b0, qf});
  end

  // sine rounding and clamp
  always_comb begin
    sraw = {1'b0, prod_r[57:28]} + 31'd2048;
    srnd = sraw[30:12];
    smag = (srnd > 19'd65536) ? 17'd65536 : srnd[16:0];
  end

  // cosine clamp, rounding and result signs
  always_comb begin
    cpos = t_r[30] ? 30'd0 : t_r[29:0];
    craw = {1'b0, cpos} + 31'd2048;
    cmag = craw[28:12];
    stat.busy  = (state_r != vctp_pkg::TRIG_IDLE);
    stat.done  = (state_r == vctp_pkg::TRIG_FIN);
    stat.sin_v = (neg_r ^ flip_r) ? -$signed({1'b0, smag_r}) : $signed({1'b0, smag_r});
    stat.cos_v = flip_r ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vctp_pkg::TRIG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vctp_pkg::TRIG_IDLE: if (start) state_nxt = vctp_pkg::TRIG_SQR;
      vctp_pkg::TRIG_SQR:  state_nxt = vctp_pkg::TRIG_X2;
      vctp_pkg::TRIG_X2:   state_nxt = vctp_pkg::TRIG_MUL;
      vctp_pkg::TRIG_MUL:  state_nxt = vctp_pkg::TRIG_RCP;
      vctp_pkg::TRIG_RCP:  state_nxt = vctp_pkg::TRIG_FIX;
      vctp_pkg::TRIG_FIX: begin
        if (step_r == vctp_pkg::SINE_LAST_STEP) begin
          state_nxt = vctp_pkg::TRIG_SINM;
        end else if (step_r == vctp_pkg::COS_LAST_STEP) begin
          state_nxt = vctp_pkg::TRIG_FIN;
        end else begin
          state_nxt = vctp_pkg::TRIG_MUL;
        end
      end
      vctp_pkg::TRIG_SINM: state_nxt = vctp_pkg::TRIG_SINR;
      vctp_pkg::TRIG_SINR: state_nxt = vctp_pkg::TRIG_MUL;
      vctp_pkg::TRIG_FIN:  state_nxt = vctp_pkg::TRIG_IDLE;
      default:             state_nxt = vctp_pkg::TRIG_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    case (state_r)
      vctp_pkg::TRIG_IDLE: begin
        ax_r   <= axf[28:0];
        neg_r  <= thf[33];
        flip_r <= flipf;
      end
      vctp_pkg::TRIG_X2: begin
        x2_r   <= prod_r[57:28];
        t_r    <= $signed({2'b00, vctp_pkg::Q28_ONE});
        step_r <= 4'd0;
      end
      vctp_pkg::TRIG_RCP: v_r <= prod_r[57:28];
      vctp_pkg::TRIG_FIX: begin
        t_r    <= t_fix;
        step_r <= step_r + 4'd1;
      end
      vctp_pkg::TRIG_SINR: begin
        smag_r <= smag;
        t_r    <= $signed({2'b00, vctp_pkg::Q28_ONE});
      end
      default: ;
    endcase
  end

endmodule

[hdl/vctp_front.sv]
module vctp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  // vertex input
  input  logic                               in_push,
  output logic                               in_full,
  input  vctp_pkg::in_item_t                 in_data,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vctp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vctp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // queue toward the back end
  output logic                               q_valid,
  output vctp_pkg::in_item_t                 q_item,
  input  logic                               q_take,
  output vctp_pkg::view_cfg_t                view_cfg
);

  vctp_pkg::trig_stat_t trig_stat;

  logic                     cfg_wr;
  logic                     trig_start;
  logic [1:0]               sel_r;
  logic signed [17:0]       trig_r [6];
  logic signed [31:0]       pos_x_r;
  logic signed [31:0]       pos_y_r;
  logic signed [31:0]       pos_z_r;
  logic [30:0]              width_r;
  logic [30:0]              height_r;

  vctp_pkg::in_item_t                  qmem_r [vctp_pkg::QUEUE_DEPTH];
  logic [vctp_pkg::QUEUE_AW-1:0]       wr_ptr_r;
  logic [vctp_pkg::QUEUE_AW-1:0]       rd_ptr_r;
  logic [vctp_pkg::QUEUE_AW:0]         cnt_r;
  logic                                push_ok;

  // sine and cosine unit, one angle at a time
  vctp_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (cfg_data[15:0]),
    .stat  (trig_stat)
  );

  assign cfg_ready  = !trig_stat.busy;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign trig_start = cfg_wr && ((cfg_index == vctp_pkg::REG_ANGLE_X) ||
                                 (cfg_index == vctp_pkg::REG_ANGLE_Y) ||
                                 (cfg_index == vctp_pkg::REG_ANGLE_Z));

  // register file and trig table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r    <= 2'd0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      pos_z_r  <= '0;
      width_r  <= vctp_pkg::VIEW_WIDTH_RST;
      height_r <= vctp_pkg::VIEW_HEIGHT_RST;
      for (int i = 0; i < 6; i++) trig_r[i] <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          vctp_pkg::REG_ANGLE_X,
          vctp_pkg::REG_ANGLE_Y,
          vctp_pkg::REG_ANGLE_Z: sel_r    <= cfg_index[1:0];
          vctp_pkg::REG_POS_X:   pos_x_r  <= cfg_data;
          vctp_pkg::REG_POS_Y:   pos_y_r  <= cfg_data;
          vctp_pkg::REG_POS_Z:   pos_z_r  <= cfg_data;
          vctp_pkg::REG_VIEW_W:  width_r  <= cfg_data[30:0];
          vctp_pkg::REG_VIEW_H:  height_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (trig_stat.done) begin
        trig_r[{sel_r, 1'b0}] <= trig_stat.sin_v;
        trig_r[{sel_r, 1'b1}] <= trig_stat.cos_v;
      end
    end
  end

  always_comb begin
    view_cfg.sin_x       = trig_r[0];
    view_cfg.cos_x       = trig_r[1];
    view_cfg.sin_y       = trig_r[2];
    view_cfg.cos_y       = trig_r[3];
    view_cfg.sin_z       = trig_r[4];
    view_cfg.cos_z       = trig_r[5];
    view_cfg.pos_x       = pos_x_r;
    view_cfg.pos_y       = pos_y_r;
    view_cfg.pos_z       = pos_z_r;
    view_cfg.view_width  = width_r;
    view_cfg.view_height = height_r;
  end

  // input queue, held off while a new angle is being evaluated
  assign in_full = (cnt_r == (vctp_pkg::QUEUE_AW+1)'(vctp_pkg::QUEUE_DEPTH)) || trig_stat.busy;
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign q_item  = qmem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) qmem_r[wr_ptr_r] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_take)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push_ok, q_take})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[hdl/vctp_div.sv]
module vctp_div #(
  parameter int QW = 11,
  parameter int NW = 46
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] rem_in [QW];
  logic [NW-1:0] den_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [NW-1:0] rem_r  [QW];
  logic [NW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW-1:0] dsh;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in[i] = num;
      assign den_in[i] = NW'(den);
      assign quo_in[i] = '0;
    end else begin : g_next
      assign rem_in[i] = rem_r[i-1];
      assign den_in[i] = den_r[i-1];
      assign quo_in[i] = quo_r[i-1];
    end

    assign dsh = den_in[i] << (QW - 1 - i);
    assign ge  = (rem_in[i] >= dsh);

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? (rem_in[i] - dsh) : rem_in[i];
      den_r[i] <= den_in[i];
      quo_r[i] <= quo_in[i] | (QW'(ge) << (QW - 1 - i));
    end
  end

  assign quo = quo_r[QW-1];

endmodule

[hdl/vctp_back.sv]
module vctp_back #(
  parameter int VIEW_COLUMNS = vctp_pkg::VIEW_COLUMNS_DEF,
  parameter int VIEW_ROWS    = vctp_pkg::VIEW_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  vctp_pkg::in_item_t   q_item,
  output logic                 q_take,
  input  vctp_pkg::view_cfg_t  view_cfg,
  output logic                 out_empty,
  input  logic                 out_pop,
  output vctp_pkg::out_item_t  out_data
);

  localparam int QW_C      = $clog2(VIEW_COLUMNS + 1);
  localparam int QW_R      = $clog2(VIEW_ROWS + 1);
  localparam int QW        = (QW_C > QW_R) ? QW_C : QW_R;
  localparam int NW        = QW + 35;
  localparam int LAT       = QW + 10;
  localparam int OUT_DEPTH = 2 ** $clog2(LAT + 2);
  localparam int PW        = $clog2(OUT_DEPTH);
  localparam int OW        = $clog2(OUT_DEPTH + 1);

  function automatic logic signed [53:0] rmul(input logic signed [35:0] a,
                                              input logic signed [17:0] b);
    return a * b;
  endfunction

  // round half up by 16 bits
  function automatic logic signed [35:0] rnd(input logic signed [54:0] s);
    logic signed [54:0] t;
    t = s + 55'sd32768;
    return t[51:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [LAT-1:0] vld_r;

  // rotation stages
  logic signed [53:0] s1_pa_r, s1_pb_r, s1_pc_r, s1_pd_r;
  logic signed [35:0] s1_x_r;
  logic signed [35:0] s2_x_r, s2_y_r, s2_z_r;
  logic signed [53:0] s3_pa_r, s3_pb_r, s3_pc_r, s3_pd_r;
  logic signed [35:0] s3_y_r;
  logic signed [35:0] s4_x_r, s4_y_r, s4_z_r;
  logic signed [53:0] s5_pa_r, s5_pb_r, s5_pc_r, s5_pd_r;
  logic signed [35:0] s5_z_r;
  logic signed [35:0] s6_x_r, s6_y_r, s6_z_r;
  // translation, visibility and pixel numerators
  logic signed [31:0] s7_x_r, s7_y_r, s7_z_r;
  vctp_pkg::out_item_t s8_item_r;
  logic signed [33:0] s8_ax_r, s8_ay_r;
  vctp_pkg::out_item_t s9_item_r;
  logic signed [NW-1:0] s9_px_r, s9_py_r;
  vctp_pkg::out_item_t s10_item_r;
  logic [NW-1:0] s10_nx_r, s10_ny_r;
  vctp_pkg::out_item_t dly_item_r [QW];

  logic signed [35:0] x0, y0, z0;
  logic signed [32:0] abs_x, abs_y;
  logic               vis;
  logic [QW-1:0]      quo_x, quo_y;
  logic [QW-1:0]      col_c, row_c;
  vctp_pkg::out_item_t fin_item;

  vctp_pkg::out_item_t fifo_r [OUT_DEPTH];
  logic [PW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [OW-1:0]       fcnt_r, occ_r;
  logic                fifo_wr, fifo_rd;

  assign x0 = 36'(q_item.vertex_x);
  assign y0 = 36'(q_item.vertex_y);
  assign z0 = 36'(q_item.vertex_z);

  // issue only when the result queue has room for everything in flight
  assign q_take = q_valid && (occ_r != OW'(OUT_DEPTH));

  // rotate about x, then y, then z
  always_ff @(posedge clk) begin
    s1_pa_r <= rmul(y0, view_cfg.cos_x);
    s1_pb_r <= rmul(z0, view_cfg.sin_x);
    s1_pc_r <= rmul(z0, view_cfg.cos_x);
    s1_pd_r <= rmul(y0, view_cfg.sin_x);
    s1_x_r  <= x0;

    s2_y_r <= rnd(55'(s1_pa_r) + 55'(s1_pb_r));
    s2_z_r <= rnd(55'(s1_pc_r) - 55'(s1_pd_r));
    s2_x_r <= s1_x_r;

    s3_pa_r <= rmul(s2_x_r, view_cfg.cos_y);
    s3_pb_r <= rmul(s2_z_r, view_cfg.sin_y);
    s3_pc_r <= rmul(s2_x_r, view_cfg.sin_y);
    s3_pd_r <= rmul(s2_z_r, view_cfg.cos_y);
    s3_y_r  <= s2_y_r;

    s4_x_r <= rnd(55'(s3_pa_r) - 55'(s3_pb_r));
    s4_z_r <= rnd(55'(s3_pc_r) + 55'(s3_pd_r));
    s4_y_r <= s3_y_r;

    s5_pa_r <= rmul(s4_x_r, view_cfg.cos_z);
    s5_pb_r <= rmul(s4_y_r, view_cfg.sin_z);
    s5_pc_r <= rmul(s4_y_r, view_cfg.cos_z);
    s5_pd_r <= rmul(s4_x_r, view_cfg.sin_z);
    s5_z_r  <= s4_z_r;

    s6_x_r <= rnd(55'(s5_pa_r) + 55'(s5_pb_r));
    s6_y_r <= rnd(55'(s5_pc_r) - 55'(s5_pd_r));
    s6_z_r <= s5_z_r;
  end

  // visibility from the saturated camera coordinates
  always_comb begin
    abs_x = s7_x_r[31] ? -33'(s7_x_r) : 33'(s7_x_r);
    abs_y = s7_y_r[31] ? -33'(s7_y_r) : 33'(s7_y_r);
    vis   = (view_cfg.view_width != '0) && (view_cfg.view_height != '0) &&
            ({abs_x, 1'b0} <= {3'b000, view_cfg.view_width}) &&
            ({abs_y, 1'b0} <= {3'b000, view_cfg.view_height});
  end

  // translate, test, and form (2p + size) * res + size
  always_ff @(posedge clk) begin
    s7_x_r <= sat32(37'(s6_x_r) - 37'(view_cfg.pos_x));
    s7_y_r <= sat32(37'(s6_y_r) - 37'(view_cfg.pos_y));
    s7_z_r <= sat32(37'(s6_z_r) - 37'(view_cfg.pos_z));

    s8_item_r.cam_x        <= s7_x_r;
    s8_item_r.cam_y        <= s7_y_r;
    s8_item_r.cam_z        <= s7_z_r;
    s8_item_r.visible      <= vis;
    s8_item_r.pixel_column <= '0;
    s8_item_r.pixel_row    <= '0;
    s8_ax_r <= $signed({s7_x_r[31], s7_x_r, 1'b0}) + $signed({3'b000, view_cfg.view_width});
    s8_ay_r <= $signed({s7_y_r[31], s7_y_r, 1'b0}) + $signed({3'b000, view_cfg.view_height});

    s9_item_r <= s8_item_r;
    s9_px_r   <= s8_ax_r * $signed({1'b0, QW'(VIEW_COLUMNS)});
    s9_py_r   <= s8_ay_r * $signed({1'b0, QW'(VIEW_ROWS)});

    s10_item_r <= s9_item_r;
    s10_nx_r   <= s9_px_r[NW-1] ? '0 :
                  NW'(s9_px_r + $signed(NW'(view_cfg.view_width)));
    s10_ny_r   <= s9_py_r[NW-1] ? '0 :
                  NW'(s9_py_r + $signed(NW'(view_cfg.view_height)));
  end

  // divide by twice the view size
  vctp_div #(.QW(QW), .NW(NW)) u_div_col (
    .clk (clk),
    .num (s10_nx_r),
    .den ({view_cfg.view_width, 1'b0}),
    .quo (quo_x)
  );

  vctp_div #(.QW(QW), .NW(NW)) u_div_row (
    .clk (clk),
    .num (s10_ny_r),
    .den ({view_cfg.view_height, 1'b0}),
    .quo (quo_y)
  );

  // carry the item alongside the divider stages
  always_ff @(posedge clk) begin
    dly_item_r[0] <= s10_item_r;
    for (int i = 1; i < QW; i++) dly_item_r[i] <= dly_item_r[i-1];
  end

  // clamp to the last column and row
  always_comb begin
    col_c = (quo_x > QW'(VIEW_COLUMNS - 1)) ? QW'(VIEW_COLUMNS - 1) : quo_x;
    row_c = (quo_y > QW'(VIEW_ROWS - 1)) ? QW'(VIEW_ROWS - 1) : quo_y;
    fin_item = dly_item_r[QW-1];
    fin_item.pixel_column = fin_item.visible ? vctp_pkg::PIX_W'(col_c) : '0;
    fin_item.pixel_row    = fin_item.visible ? vctp_pkg::PIX_W'(row_c) : '0;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], q_take};
    end
  end

  // result queue
  assign fifo_wr   = vld_r[LAT-1];
  assign fifo_rd   = out_pop && !out_empty;
  assign out_empty = (fcnt_r == '0);
  assign out_data  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (fifo_wr) fifo_r[wr_ptr_r] <= fin_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
      occ_r    <= '0;
    end else begin
      if (fifo_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (fifo_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({fifo_wr, fifo_rd})
        2'b10:   fcnt_r <= fcnt_r + 1'b1;
        2'b01:   fcnt_r <= fcnt_r - 1'b1;
        default: fcnt_r <= fcnt_r;
      endcase
      case ({q_take, fifo_rd})
        2'b10:   occ_r <= occ_r + 1'b1;
        2'b01:   occ_r <= occ_r - 1'b1;
        default: occ_r <= occ_r;
      endcase
    end
  end

endmodule

[test/testbench.sv]
module testbench;

  typedef logic [vctp_pkg::CFG_IDX_W-1:0] cfg_index_t;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam cfg_index_t UNUSED_INDEX = 4'd11;
  localparam int COLS = vctp_pkg::VIEW_COLUMNS_DEF;
  localparam int ROWS = vctp_pkg::VIEW_ROWS_DEF;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  vctp_pkg::in_item_t in_data;
  logic out_empty;
  logic out_pop;
  vctp_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  cfg_index_t cfg_index;
  logic [vctp_pkg::CFG_DATA_W-1:0] cfg_data;

  vertex_camera_transform_project_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow view settings
  logic signed [vctp_pkg::TRIG_W-1:0] sin_tab [3];
  logic signed [vctp_pkg::TRIG_W-1:0] cos_tab [3];
  logic signed [31:0] cam_pos [3];
  logic [30:0] view_w;
  logic [30:0] view_h;

  vctp_pkg::out_item_t projected_q [$];
  int mismatches;
  int stray_results;
  int results_seen;
  int vertices_sent;
  int visible_seen;
  int reg_writes;
  int cycles;
  int pop_hold;
  int pop_gap;
  bit no_idle;

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, projected_q.size());
      $display("[vertex_camera_transform_project_top] ERROR");
      $finish;
    end
  end

  // sine and cosine of a q3.13 angle, q1.16 results
  function automatic void calc_trig(input int q13,
                                    output logic signed [vctp_pkg::TRIG_W-1:0] sv,
                                    output logic signed [vctp_pkg::TRIG_W-1:0] cv);
    longint sk [5] = '{110, 72, 42, 20, 6};
    longint ck [5] = '{132, 90, 56, 30, 12};
    longint one, th, ax, x2, t, s, c;
    bit flip, neg;
    one = longint'(1) <<< 28;
    th = longint'(q13) * 32768;
    flip = 1'b0;
    if (th > longint'(vctp_pkg::Q28_HALF_PI)) begin
      th = th - longint'(vctp_pkg::Q28_PI);
      flip = 1'b1;
    end else if (th < -longint'(vctp_pkg::Q28_HALF_PI)) begin
      th = th + longint'(vctp_pkg::Q28_PI);
      flip = 1'b1;
    end
    neg = th < 0;
    ax = neg ? -th : th;
    x2 = (ax * ax) >>> 28;
    t = one;
    for (int i = 0; i < 5; i++) t = one - ((x2 * t) >>> 28) / sk[i];
    s = (ax * t) >>> 28;
    s = (s + 2048) >>> 12;
    if (s > 65536) s = 65536;
    t = one;
    for (int i = 0; i < 5; i++) t = one - ((x2 * t) >>> 28) / ck[i];
    c = one - ((x2 * t) >>> 28) / 2;
    if (c < 0) c = 0;
    c = (c + 2048) >>> 12;
    if (neg) s = -s;
    if (flip) begin
      s = -s;
      c = -c;
    end
    sv = s[vctp_pkg::TRIG_W-1:0];
    cv = c[vctp_pkg::TRIG_W-1:0];
  endfunction

  function automatic longint round16(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint pixel_index(input longint p, input longint size, input longint res);
    longint num, q;
    num = 2 * p * res + size * res + size;
    if (num < 0) num = 0;
    q = num / (2 * size);
    if (q > res - 1) q = res - 1;
    return q;
  endfunction

  // camera-space point and pixel of one vertex
  function automatic vctp_pkg::out_item_t project_vertex(input vctp_pkg::in_item_t v);
    vctp_pkg::out_item_t r;
    longint x, y, z, y1, z1, x2, z2, x3, y3, cx, cy, cz, ax, ay, w, h;
    longint col, row;
    bit vis;
    x = v.vertex_x;
    y = v.vertex_y;
    z = v.vertex_z;
    y1 = round16(y * sin_tab[0] * 0 + y * cos_tab[0] + z * sin_tab[0]);
    z1 = round16(z * cos_tab[0] - y * sin_tab[0]);
    x2 = round16(x * cos_tab[1] - z1 * sin_tab[1]);
    z2 = round16(x * sin_tab[1] + z1 * cos_tab[1]);
    x3 = round16(x2 * cos_tab[2] + y1 * sin_tab[2]);
    y3 = round16(y1 * cos_tab[2] - x2 * sin_tab[2]);
    cx = sat32(x3 - cam_pos[0]);
    cy = sat32(y3 - cam_pos[1]);
    cz = sat32(z2 - cam_pos[2]);
    ax = cx < 0 ? -cx : cx;
    ay = cy < 0 ? -cy : cy;
    w = longint'(view_w);
    h = longint'(view_h);
    vis = w != 0 && h != 0 && 2 * ax <= w && 2 * ay <= h;
    col = vis ? pixel_index(cx, w, COLS) : 0;
    row = vis ? pixel_index(cy, h, ROWS) : 0;
    r.cam_x = cx[31:0];
    r.cam_y = cy[31:0];
    r.cam_z = cz[31:0];
    r.visible = vis;
    r.pixel_column = col[vctp_pkg::PIX_W-1:0];
    r.pixel_row = row[vctp_pkg::PIX_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // result checker
  always @(posedge clk) begin
    vctp_pkg::out_item_t want;
    if (rst_n && !out_empty && out_pop) begin
      results_seen++;
      if (projected_q.size() == 0) begin
        stray_results++;
        if (stray_results <= 10) $display("result with nothing pending: %p", out_data);
      end else begin
        want = projected_q.pop_front();
        if (want.visible) visible_seen++;
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: cam_x exp %h got %h, cam_y exp %h got %h, cam_z exp %h got %h",
                     want.cam_x, out_data.cam_x, want.cam_y, out_data.cam_y,
                     want.cam_z, out_data.cam_z);
            $display("  visible exp %b got %b, column exp %0d got %0d, row exp %0d got %0d",
                     want.visible, out_data.visible, want.pixel_column, out_data.pixel_column,
                     want.pixel_row, out_data.pixel_row);
          end
        end
      end
    end
  end

  // receiver with random stalls and forced hold-offs
  initial begin
    int r;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap--;
      end else if (no_idle) begin
        out_pop <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) pop_gap = $urandom_range(10, 60);
        else if (r < 20) pop_gap = $urandom_range(0, 2);
        out_pop <= (r >= 20);
      end
    end
  end

  task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z);
    vctp_pkg::in_item_t v;
    int gap;
    v.vertex_x = x;
    v.vertex_y = y;
    v.vertex_z = z;
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (in_full);
    projected_q.push_back(project_vertex(v));
    vertices_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (projected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      vctp_pkg::REG_ANGLE_X, vctp_pkg::REG_ANGLE_Y, vctp_pkg::REG_ANGLE_Z:
        calc_trig(-int'($signed(value[15:0])), sin_tab[idx], cos_tab[idx]);
      vctp_pkg::REG_POS_X, vctp_pkg::REG_POS_Y, vctp_pkg::REG_POS_Z:
        cam_pos[idx - vctp_pkg::REG_POS_X] = value;
      vctp_pkg::REG_VIEW_W: view_w = value[30:0];
      vctp_pkg::REG_VIEW_H: view_h = value[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_angle(input cfg_index_t idx, input logic signed [15:0] a);
    write_reg(idx, {16'($urandom_range(0, 16'hffff)), a});
  endtask

  function automatic logic [31:0] rand_coord(input logic [30:0] span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $signed($urandom_range(0, span)) - $signed({1'b0, span >> 1});
    if (r < 75) return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    return $urandom;
  endfunction

  task automatic test_reset_state();
    // trig table is zero until an angle is written
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh00012345);
    send_vertex(32'sh80000000, 32'sh7fffffff, 32'shffffffff);
    send_vertex(0, 0, 0);
    drain_results();
  endtask

  task automatic test_directed();
    write_angle(vctp_pkg::REG_ANGLE_X, 0);
    write_angle(vctp_pkg::REG_ANGLE_Y, 0);
    write_angle(vctp_pkg::REG_ANGLE_Z, 0);
    send_vertex(0, 0, 0);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000);
    // exact edges of the default view rectangle
    send_vertex(32'sh00190000, -32'sh000c8000, 0);
    send_vertex(32'sh00190001, 0, 0);
    drain_results();
    // extreme angles and the fold near half pi
    write_angle(vctp_pkg::REG_ANGLE_X, 16'sh8000);
    write_angle(vctp_pkg::REG_ANGLE_Y, 16'sh7fff);
    write_angle(vctp_pkg::REG_ANGLE_Z, 16'sd12868);
    send_vertex(32'sh00100000, -32'sh00080000, 32'sh00040000);
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    drain_results();
    write_angle(vctp_pkg::REG_ANGLE_X, -16'sd12869);
    write_angle(vctp_pkg::REG_ANGLE_Y, 16'sd12869);
    write_angle(vctp_pkg::REG_ANGLE_Z, -16'sd12868);
    send_vertex(32'sh00030000, 32'sh00050000, -32'sh00070000);
    drain_results();
    // tiny view and saturating position
    write_reg(vctp_pkg::REG_VIEW_W, 32'h80000001);
    write_reg(vctp_pkg::REG_VIEW_H, 1);
    write_angle(vctp_pkg::REG_ANGLE_X, 0);
    write_angle(vctp_pkg::REG_ANGLE_Y, 0);
    write_angle(vctp_pkg::REG_ANGLE_Z, 0);
    send_vertex(0, 0, 0);
    send_vertex(1, 0, 0);
    drain_results();
    write_reg(vctp_pkg::REG_POS_X, 32'h80000000);
    write_reg(vctp_pkg::REG_POS_Y, 32'h7fffffff);
    write_reg(vctp_pkg::REG_POS_Z, 32'h80000000);
    write_reg(vctp_pkg::REG_VIEW_W, 32'h7fffffff);
    write_reg(vctp_pkg::REG_VIEW_H, 32'h7fffffff);
    write_reg(UNUSED_INDEX, 32'hdeadbeef);
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_vertex(0, 0, 0);
    send_vertex(-32'sh3fffffff, 32'sh3fffffff, 0);
    drain_results();
  endtask

  task automatic test_backpressure();
    pop_hold = 400;
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++) send_vertex(rand_coord(view_w), rand_coord(view_h), $urandom);
    no_idle = 1'b0;
    drain_results();
  endtask

  task automatic randomize_view();
    int r;
    for (int a = 0; a < 3; a++) begin
      r = $urandom_range(0, 9);
      write_angle(cfg_index_t'(a),
                  16'(r == 0 ? 16'sh8000 : r == 1 ? 16'sh7fff : r == 2 ? 16'sh0000 : $urandom));
    end
    for (int p = 0; p < 3; p++) begin
      r = $urandom_range(0, 9);
      write_reg(cfg_index_t'(vctp_pkg::REG_POS_X + p),
                r == 0 ? 32'h80000000 : r == 1 ? 32'h7fffffff :
                $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
    end
    r = $urandom_range(0, 9);
    write_reg(vctp_pkg::REG_VIEW_W,
              r == 0 ? 32'h7fffffff : r == 1 ? 1 : $urandom_range(32'h10000, 32'h4000000));
    r = $urandom_range(0, 9);
    write_reg(vctp_pkg::REG_VIEW_H,
              r == 0 ? 32'h7fffffff : r == 1 ? 1 : $urandom_range(32'h10000, 32'h4000000));
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 8; phase++) begin
      randomize_view();
      no_idle = (phase % 3 == 2);
      for (int i = 0; i < 250; i++) send_vertex(rand_coord(view_w), rand_coord(view_h), $urandom);
      no_idle = 1'b0;
      drain_results();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    pop_hold = 0;
    pop_gap = 0;
    no_idle = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sin_tab[i] = '0;
      cos_tab[i] = '0;
      cam_pos[i] = '0;
    end
    view_w = vctp_pkg::VIEW_WIDTH_RST;
    view_h = vctp_pkg::VIEW_HEIGHT_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    test_reset_state();
    test_directed();
    test_backpressure();
    test_random_stream();
    drain_results();

    $display("%0d vertices sent, %0d results checked (%0d visible), %0d register writes",
             vertices_sent, results_seen, visible_seen, reg_writes);
    $display("%0d mismatches, %0d stray results, %0d left pending",
             mismatches, stray_results, projected_q.size());
    if (mismatches == 0 && stray_results == 0 && projected_q.size() == 0) begin
      $display("[vertex_camera_transform_project_top] OK");
    end else begin
      $display("[vertex_camera_transform_project_top] ERROR");
    end
    $finish;
  end

endmodule

[vertex_camera_transform_project_top.f]
hdl/vctp_pkg.sv
hdl/vctp_trig.sv
hdl/vctp_front.sv
hdl/vctp_div.sv
hdl/vctp_back.sv
hdl/vertex_camera_transform_project_top.sv
test/testbench.sv
